FILE: rtl/calendar_date_day_number_converter_assert.svh
// Assertion macros for the calendar date / day number converter
`ifndef CALENDAR_DATE_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define CALENDAR_DATE_DAY_NUMBER_CONVERTER_ASSERT_SVH

// Check that a condition implies a consequence on the same edge
`define CDC_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence on the next edge
`define CDC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cddn_pkg.sv
// Shared types, constants and helpers of the date / day number converter
package cddn_pkg;

	localparam int unsigned MAX_YEAR = 32767;
	localparam int unsigned GAP_YEAR = 1582;
	localparam int unsigned GAP_LAST_DAY = 577736;
	localparam int unsigned GAP_DAYS = 10;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_DATE = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;

	localparam logic REQ_DATE = 1'b0;
	localparam logic REQ_NUMBER = 1'b1;

	// Divide by 100 through a reciprocal multiply, exact below 2^17
	function automatic logic [16:0] div100(input logic [16:0] x);
		logic [35:0] p;
		begin
			p = 36'(x) * 36'd167773;
			return 17'(p >> 24);
		end
	endfunction

	// Remainder by 7 through a reciprocal multiply, exact below 2^25
	function automatic logic [2:0] mod7(input logic [24:0] x);
		logic [50:0] p;
		logic [24:0] q;
		logic [24:0] r;
		begin
			p = 51'(x) * 51'd38347923;
			q = 25'(p >> 28);
			r = x - 25'(q * 25'd7);
			return r[2:0];
		end
	endfunction

	// Days from 1 Jan year 1 to 1 Jan of y (without gap)
	function automatic logic [24:0] days_before_year(input logic [16:0] y);
		logic [16:0] m;
		logic [16:0] q;
		logic [24:0] r;
		begin
			m = y - 17'd1;
			q = div100(m);
			r = 25'(m) * 25'd365 + 25'(m >> 2);
			if (m > 17'(GAP_YEAR))
				r = r - 25'(q) + 25'(q >> 2) + 25'd12;
			return r;
		end
	endfunction

	localparam logic [23:0] MAX_DAY = 24'(days_before_year(17'(MAX_YEAR + 1)) - 25'd1
		- 25'(GAP_DAYS));

	function automatic logic is_leap(input logic [14:0] y);
		logic [16:0] q;
		begin
			q = div100({2'b0, y});
			if (y[1:0] != 2'd0) return 1'b0;
			if (y <= 15'(GAP_YEAR)) return 1'b1;
			if ({2'b0, y} != 17'(q * 17'd100)) return 1'b1;
			return q[1:0] == 2'd0;
		end
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
				4'd2: return leap ? 5'd29 : 5'd28;
				default: return 5'd0;
			endcase
		end
	endfunction

	// Days before the first of month m in a year
	function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
		logic [8:0] r;
		begin
			case (m)
				4'd1: r = 9'd0;
				4'd2: r = 9'd31;
				4'd3: r = 9'd59;
				4'd4: r = 9'd90;
				4'd5: r = 9'd120;
				4'd6: r = 9'd151;
				4'd7: r = 9'd181;
				4'd8: r = 9'd212;
				4'd9: r = 9'd243;
				4'd10: r = 9'd273;
				4'd11: r = 9'd304;
				default: r = 9'd334;
			endcase
			if (leap && m > 4'd2) r = r + 9'd1;
			return r;
		end
	endfunction

	typedef struct packed {
		logic        vld;
		logic        req;
	} ctl_t;

endpackage

FILE: rtl/calendar_date_day_number_converter.sv
// Top level of the calendar date / day number converter
// A word taken with start passes the registers s1, s2 and s3 before its result shows with done.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The stage depth is set by the year offset adders and the year estimate multiply.
// Reset clears the valid bits of the pipeline; payload registers are not reset.
// The receiver cannot stall: the done strobe marks each result for one cycle.
module calendar_date_day_number_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [4:0]  day_in,
	input  logic [3:0]  month_in,
	input  logic [14:0] year_in,
	input  logic [23:0] day_number_in,
	output logic        done,
	output logic [23:0] day_number_out,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [14:0] year_out,
	output logic [2:0]  weekday,
	output logic [1:0]  status
);
	import cddn_pkg::*;
	`include "calendar_date_day_number_converter_assert.svh"

	ctl_t        ctl_s1, ctl_s2, ctl_s3;
	logic [4:0]  d_s1, d_s2, d_s3;
	logic [3:0]  m_s1, m_s2, m_s3;
	logic [14:0] y_s1, y_s2, y_s3;
	logic [23:0] n_s1, n_s2, n_s3;
	logic [23:0] dn_num;
	logic        dn_bad, nd_big;
	logic [4:0]  nd_d;
	logic [3:0]  nd_m;
	logic [14:0] nd_y;

	assign busy = 1'b0;

	cddn_date2num u_d2n (.clk(clk), .day_in(day_in), .month_in(month_in),
		.year_in(year_in), .num(dn_num), .bad(dn_bad));
	cddn_num2date u_n2d (.clk(clk), .day_number_in(day_number_in), .d(nd_d),
		.m(nd_m), .y(nd_y), .too_large(nd_big));

	// Advance the control and echo words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= '{vld: start, req: req_type};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= day_in; m_s1 <= month_in; y_s1 <= year_in; n_s1 <= day_number_in;
		d_s2 <= d_s1; m_s2 <= m_s1; y_s2 <= y_s1; n_s2 <= n_s1;
		d_s3 <= d_s2; m_s3 <= m_s2; y_s3 <= y_s2; n_s3 <= n_s2;
	end

	// Build the result word
	logic [23:0] num_c;
	logic        err_c;
	logic [24:0] wk_c;
	always_comb begin
		day_number_out = '0; day_out = '0; month_out = '0; year_out = '0;
		weekday = '0; status = ST_OK;
		if (ctl_s3.req == REQ_DATE) begin
			num_c = dn_num;
			err_c = dn_bad;
			status = dn_bad ? ST_BAD_DATE : ST_OK;
			day_out = d_s3; month_out = m_s3; year_out = y_s3;
		end else begin
			num_c = n_s3;
			err_c = nd_big;
			status = nd_big ? ST_TOO_LARGE : ST_OK;
			day_out = nd_d; month_out = nd_m; year_out = nd_y;
		end
		wk_c = 25'(num_c) + 25'd5;
		day_number_out = num_c;
		weekday = mod7(wk_c);
		if (err_c) begin
			day_number_out = '0; day_out = '0; month_out = '0; year_out = '0;
			weekday = '0;
		end
	end

	assign done = ctl_s3.vld;

	`CDC_ASSERT_NEXT(a_start_flows, clk, arst_n, start, ctl_s1.vld, "start lost")
	`CDC_ASSERT_IMP(a_ok_month, clk, arst_n, done && status == ST_OK,
		month_out >= 4'd1 && month_out <= 4'd12, "bad month on ok")
	`CDC_ASSERT_IMP(a_err_zero, clk, arst_n, done && status != ST_OK,
		day_number_out == 24'd0 && year_out == 15'd0, "error word not cleared")
endmodule

FILE: rtl/cddn_date2num.sv
// Date to day number path: validation, year offset, month offset, gap fix
module cddn_date2num (
	input  logic        clk,
	input  logic [4:0]  day_in,
	input  logic [3:0]  month_in,
	input  logic [14:0] year_in,
	output logic [23:0] num,
	output logic        bad
);
	import cddn_pkg::*;

	logic        bad_s1;
	logic [24:0] ybase_s1;
	logic [8:0]  moff_s1;
	logic [4:0]  d_s1;
	logic [24:0] sum_s2;
	logic        bad_s2;
	logic [23:0] num_s3;
	logic        bad_s3;

	logic leap_c;
	assign leap_c = is_leap(year_in);

	// Stage 1: check the date, look up year and month offsets
	always_ff @(posedge clk) begin
		ybase_s1 <= days_before_year({2'b0, year_in});
		moff_s1 <= days_before_month(month_in, leap_c);
		d_s1 <= day_in;
		bad_s1 <= (year_in == 15'd0) || (month_in == 4'd0) || (month_in > 4'd12) ||
			(day_in == 5'd0) || (day_in > month_len(month_in, leap_c)) ||
			((year_in == 15'(GAP_YEAR)) && (month_in == 4'd10) &&
			 (day_in >= 5'd5) && (day_in <= 5'd14));
	end

	// Stage 2: add the parts
	always_ff @(posedge clk) begin
		sum_s2 <= ybase_s1 + 25'(moff_s1) + 25'(d_s1) - 25'd1;
		bad_s2 <= bad_s1;
	end

	// Stage 3: drop the gap days past 4 Oct 1582
	always_ff @(posedge clk) begin
		num_s3 <= (sum_s2 > 25'(GAP_LAST_DAY)) ? 24'(sum_s2 - 25'(GAP_DAYS))
			: sum_s2[23:0];
		bad_s3 <= bad_s2;
	end

	assign num = num_s3;
	assign bad = bad_s3;
endmodule

FILE: rtl/cddn_num2date.sv
// Day number to date path: gap fix, year estimate and correction, month search
module cddn_num2date (
	input  logic        clk,
	input  logic [23:0] day_number_in,
	output logic [4:0]  d,
	output logic [3:0]  m,
	output logic [14:0] y,
	output logic        too_large
);
	import cddn_pkg::*;

	logic [23:0] raw_s1;
	logic [16:0] yest_s1;
	logic        big_s1;
	logic [23:0] raw_s2;
	logic [16:0] y_s2;
	logic [24:0] b0_s2, b1_s2, b2_s2;
	logic        big_s2;
	logic [8:0]  doy_s3;
	logic [14:0] y_s3;
	logic        leap_s3, big_s3;

	logic [23:0] raw_c;
	logic [41:0] prod_c;
	assign raw_c = (day_number_in > 24'(GAP_LAST_DAY)) ? day_number_in + 24'(GAP_DAYS)
		: day_number_in;
	// Estimate year as raw*400/146097 via a reciprocal, corrected later
	assign prod_c = 42'(raw_c) * 42'd183738;

	// Stage 1: gap fix and year estimate (within one of the true year)
	always_ff @(posedge clk) begin
		raw_s1 <= raw_c;
		yest_s1 <= 17'(prod_c >> 26) + 17'd1;
		big_s1 <= day_number_in > MAX_DAY;
	end

	// Stage 2: year starts around the estimate
	always_ff @(posedge clk) begin
		raw_s2 <= raw_s1;
		y_s2 <= yest_s1;
		b0_s2 <= (yest_s1 > 17'd1) ? days_before_year(yest_s1) : 25'd0;
		b1_s2 <= days_before_year(yest_s1 + 17'd1);
		b2_s2 <= days_before_year(yest_s1 + 17'd2);
		big_s2 <= big_s1;
	end

	// Stage 3: pick the year and day of year
	always_ff @(posedge clk) begin
		logic [16:0] yy;
		logic [24:0] base;
		if (25'(raw_s2) < b0_s2) begin
			yy = y_s2 - 17'd1;
			base = days_before_year(yy);
		end else if (25'(raw_s2) < b1_s2) begin
			yy = y_s2;
			base = b0_s2;
		end else if (25'(raw_s2) < b2_s2) begin
			yy = y_s2 + 17'd1;
			base = b1_s2;
		end else begin
			yy = y_s2 + 17'd2;
			base = b2_s2;
		end
		y_s3 <= yy[14:0];
		doy_s3 <= 9'(25'(raw_s2) - base);
		leap_s3 <= is_leap(yy[14:0]);
		big_s3 <= big_s2;
	end

	// Find the month from the day of year
	always_comb begin
		logic [3:0] k;
		m = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			k = 4'(i);
			if (doy_s3 >= days_before_month(k, leap_s3)) m = k;
		end
	end

	assign d = 5'(doy_s3 - days_before_month(m, leap_s3)) + 5'd1;
	assign y = y_s3;
	assign too_large = big_s3;
endmodule

FILE: dv/calendar_date_day_number_converter_tb.sv
// Testbench for the calendar date / day number converter: directed table, then random words
module calendar_date_day_number_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cddn_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_RANDOM = 500;

	typedef struct {
		logic        req;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [14:0] y;
		logic [23:0] n;
	} word_t;

	typedef struct packed {
		logic [23:0] num;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [14:0] y;
		logic [2:0]  wd;
		logic [1:0]  st;
	} conv_t;

	// directed row: stimulus, typed-in answer and whether to use it
	typedef struct {
		word_t w;
		bit    fixed;
		conv_t r;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [4:0]  day_in;
	logic [3:0]  month_in;
	logic [14:0] year_in;
	logic [23:0] day_number_in;
	logic        done;
	logic [23:0] day_number_out;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [14:0] year_out;
	logic [2:0]  weekday;
	logic [1:0]  status;

	conv_t pending_q[$];
	int    fail_count = 0;
	int    cycle_count = 0;

	calendar_date_day_number_converter dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// days before 1 Jan of year y, gap not removed
	function automatic longint days_to_year(input longint y);
		longint p;
		p = y - 1;
		if (p <= GAP_YEAR) return p * 365 + p / 4;
		return p * 365 + p / 4 - p / 100 + p / 400 + 12;
	endfunction

	function automatic int days_in_month(input int m, input int y);
		bit lp;
		lp = (y % 4 == 0) && (y <= GAP_YEAR || y % 100 != 0 || y % 400 == 0);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11: return 30;
			2: return lp ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic conv_t convert_word(input word_t w);
		conv_t r;
		longint num, raw, top;
		int y, m, d;
		r = '{default: '0};
		if (w.req == REQ_DATE) begin
			y = int'(w.y); m = int'(w.m); d = int'(w.d);
			if (y < 1 || y > MAX_YEAR || m < 1 || m > 12 || d < 1 ||
				d > days_in_month(m, y) || (y == GAP_YEAR && m == 10 && d >= 5 && d <= 14)) begin
				r.st = ST_BAD_DATE;
				return r;
			end
			num = days_to_year(y);
			for (int k = 1; k < m; k++) num += days_in_month(k, y);
			num += d - 1;
			if (num > GAP_LAST_DAY) num -= GAP_DAYS;
		end else begin
			top = days_to_year(MAX_YEAR + 1) - 1 - GAP_DAYS;
			if (longint'(w.n) > top) begin
				r.st = ST_TOO_LARGE;
				return r;
			end
			num = longint'(w.n);
			raw = num;
			if (raw > GAP_LAST_DAY) raw += GAP_DAYS;
			y = int'(raw * 400 / 146097) + 1;
			while (y > 1 && days_to_year(y) > raw) y--;
			while (days_to_year(y + 1) <= raw) y++;
			raw -= days_to_year(y);
			m = 1;
			while (m < 12 && raw >= days_in_month(m, y)) begin
				raw -= days_in_month(m, y);
				m++;
			end
			d = int'(raw) + 1;
		end
		r.num = num[23:0];
		r.d = d[4:0];
		r.m = m[3:0];
		r.y = y[14:0];
		r.wd = 3'((num + 5) % 7);
		r.st = ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, want %0d", what, got, want);
		fail_count++;
	endtask

	// check each strobed word against the oldest pending answer
	always @(posedge clk) begin
		conv_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = pending_q.pop_front();
				if (day_number_out !== e.num)
					report_mismatch("day_number", longint'(day_number_out), longint'(e.num));
				if (day_out !== e.d) report_mismatch("day", longint'(day_out), longint'(e.d));
				if (month_out !== e.m)
					report_mismatch("month", longint'(month_out), longint'(e.m));
				if (year_out !== e.y) report_mismatch("year", longint'(year_out), longint'(e.y));
				if (weekday !== e.wd)
					report_mismatch("weekday", longint'(weekday), longint'(e.wd));
				if (status !== e.st) report_mismatch("status", longint'(status), longint'(e.st));
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("calendar_date_day_number_converter test failed");
			$finish;
		end
	end

	function automatic word_t dw(input bit q, input int d, input int m, input int y,
		input int n);
		word_t w;
		w.req = q; w.d = 5'(d); w.m = 4'(m); w.y = 15'(y); w.n = 24'(n);
		return w;
	endfunction

	function automatic word_t random_word();
		word_t w;
		int r;
		w.req = 1'($urandom_range(0, 1));
		w.d = 5'($urandom); w.m = 4'($urandom); w.y = 15'($urandom); w.n = 24'($urandom);
		r = $urandom_range(0, 9);
		if (w.req == REQ_DATE) begin
			// mostly valid dates, many near the 1582 switch and in century years
			if (r < 7) begin
				w.m = 4'($urandom_range(1, 12));
				if (r < 2) w.y = 15'($urandom_range(1575, 1605));
				else if (r < 3) w.y = 15'(100 * $urandom_range(1, 327));
				else w.y = 15'($urandom_range(1, MAX_YEAR));
				w.d = 5'($urandom_range(1, days_in_month(int'(w.m), int'(w.y))));
			end
		end else if (r < 8) begin
			w.n = (r < 2) ? 24'($urandom_range(GAP_LAST_DAY - 400, GAP_LAST_DAY + 400))
				: 24'($urandom_range(0, MAX_DAY));
		end
		return w;
	endfunction

	// drop start over a random gap, then present one word until it is taken
	task automatic send_word(input word_t w, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= w.req;
		day_in <= w.d; month_in <= w.m; year_in <= w.y; day_number_in <= w.n;
		do @(posedge clk); while (busy);
		pending_q.push_back(convert_word(w));
	endtask

	initial begin
		row_t tbl[$];
		row_t rw;
		int burst;
		start = 1'b0; req_type = 1'b0; day_in = '0; month_in = '0; year_in = '0;
		day_number_in = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: fixed answers where obvious, predictor otherwise
		tbl.push_back('{dw(REQ_DATE, 1, 1, 1, 0), 1, '{0, 1, 1, 1, 5, ST_OK}});
		tbl.push_back('{dw(REQ_NUMBER, 0, 0, 0, 0), 1, '{0, 1, 1, 1, 5, ST_OK}});
		tbl.push_back('{dw(REQ_DATE, 4, 10, 1582, 0), 1,
			'{24'(GAP_LAST_DAY), 4, 10, 1582, 3, ST_OK}});
		tbl.push_back('{dw(REQ_DATE, 15, 10, 1582, 0), 1,
			'{24'(GAP_LAST_DAY + 1), 15, 10, 1582, 4, ST_OK}});
		tbl.push_back('{dw(REQ_DATE, 5, 10, 1582, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 14, 10, 1582, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 1, 1, 0, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 1, 0, 2000, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 1, 15, 2000, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 0, 5, 2000, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 31, 4, 2000, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_DATE, 29, 2, 1900, 0), 1, '{0, 0, 0, 0, 0, ST_BAD_DATE}});
		tbl.push_back('{dw(REQ_NUMBER, 31, 15, 32767, 24'hFFFFFF), 1,
			'{0, 0, 0, 0, 0, ST_TOO_LARGE}});
		tbl.push_back('{dw(REQ_NUMBER, 0, 0, 0, MAX_DAY + 1), 1, '{0, 0, 0, 0, 0, ST_TOO_LARGE}});
		tbl.push_back('{dw(REQ_NUMBER, 0, 0, 0, MAX_DAY), 1, '{MAX_DAY, 31, 12, 32767, 6, ST_OK}});
		tbl.push_back('{dw(REQ_DATE, 31, 12, 32767, 0), 0, '{default: '0}});
		tbl.push_back('{dw(REQ_DATE, 29, 2, 1500, 0), 0, '{default: '0}});
		tbl.push_back('{dw(REQ_DATE, 29, 2, 2000, 0), 0, '{default: '0}});
		tbl.push_back('{dw(REQ_DATE, 31, 12, 1582, 0), 0, '{default: '0}});
		tbl.push_back('{dw(REQ_NUMBER, 0, 0, 0, GAP_LAST_DAY + 1), 0, '{default: '0}});
		tbl.push_back('{dw(REQ_NUMBER, 0, 0, 0, 730119), 0, '{default: '0}});
		tbl.push_back('{dw(REQ_DATE, 31, 15, 32767, 24'hFFFFFF), 0, '{default: '0}});

		foreach (tbl[i]) begin
			rw = tbl[i];
			if (rw.fixed && convert_word(rw.w) != rw.r)
				report_mismatch("directed table entry", i, -1);
			send_word(rw.w, 0);
		end

		// random words in bursts with random gaps
		for (int i = 0; i < NUM_RANDOM; i += burst) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst; k++)
				send_word(random_word(), (k == 0) ? $urandom_range(1, 8) : 0);
		end
		start <= 1'b0;

		// drain
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("calendar_date_day_number_converter test passed");
		else
			$display("calendar_date_day_number_converter test failed");
		$finish;
	end
endmodule
